### rtl/core/eapol_hb_pkg.sv
// ----------------------------------------------------------------------------
// eapol_hb_pkg
// Shared types, constants and the byte coding function for the heartbeat
// engine.
// ----------------------------------------------------------------------------
package eapol_hb_pkg;

    // Transmit frame geometry
    localparam int unsigned TX_FRAME_BYTES = 45;
    localparam int unsigned TX_IDX_W       = 6;
    localparam logic [TX_IDX_W-1:0] TX_MAC_END  = 6'd12;   // bytes 0..11 are MACs
    localparam logic [TX_IDX_W-1:0] TX_KEY_POS  = 6'h18;   // coded key+count
    localparam logic [TX_IDX_W-1:0] TX_CNT_POS  = 6'h22;   // coded count
    localparam logic [TX_IDX_W-1:0] TX_LAST_IDX = 6'(TX_FRAME_BYTES - 1);
    localparam logic [7:0] TX_CNT_ADD2 = 8'h10;
    localparam logic [7:0] TX_CNT_ADD3 = 8'h2B;

    // Receive parsing
    localparam int unsigned POS_W   = 9;
    localparam logic [POS_W-1:0] POS_MAX     = 9'd511;
    localparam logic [POS_W-1:0] POS_TYPE_HI = 9'h0C;
    localparam logic [POS_W-1:0] POS_TYPE_LO = 9'h0D;
    localparam logic [POS_W-1:0] POS_CODE    = 9'h0F;
    localparam logic [POS_W-1:0] POS_HB0     = 9'h10;
    localparam logic [POS_W-1:0] POS_HB1     = 9'h11;
    localparam logic [POS_W-1:0] POS_SUBTYPE = 9'h12;
    localparam logic [POS_W-1:0] POS_HB3     = 9'h13;
    localparam logic [POS_W-1:0] POS_KEY_OFS = 9'h1B;
    localparam logic [POS_W-1:0] POS_HB_TAIL = 9'h2C;
    localparam logic [POS_W-1:0] KEY_BASE    = 9'h09D;
    localparam logic [31:0]      KEY_ADD     = 32'h0000_102B;
    localparam int unsigned      MAC_BYTES   = 12;

    // Command and result kinds
    localparam logic CMD_RX   = 1'b0;
    localparam logic CMD_SEND = 1'b1;
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_KEY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_DEST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_LOCAL = 3'd4;

    localparam logic [7:0] TX_TEMPLATE [0:TX_FRAME_BYTES-1] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h88, 8'h8E, 8'h01, 8'hBF,
        8'h00, 8'h1E, 8'hFF, 8'hFF, 8'h37, 8'h77, 8'h7F, 8'h9F,
        8'hFF, 8'hFF, 8'hD9, 8'h13,
        8'hFF, 8'hFF, 8'h37, 8'h77, 8'h7F, 8'h9F, 8'hFF, 8'hFF,
        8'hF7, 8'h2B, 8'hFF, 8'hFF,
        8'h37, 8'h77, 8'h7F, 8'h3F, 8'hFF
    };

    // Parser verdict for the byte that closes a frame
    typedef struct packed {
        logic        succ;
        logic        hb;
        logic [47:0] local_mac;
        logic [47:0] dest_mac;
        logic [31:0] key;
    } rx_verdict_t;

    // Burst start request towards the framer
    typedef struct packed {
        logic        start;
        logic        load_macs;
        logic [95:0] macs;      // dest MAC then local MAC, first byte on top
        logic [31:0] count;
        logic [31:0] key_sum;
    } tx_start_t;

    // Framer status and current byte
    typedef struct packed {
        logic       busy;
        logic [7:0] data;
        logic       last;
    } tx_byte_t;

    // Bit reverse, then invert
    function automatic logic [7:0] code_byte(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return ~r;
    endfunction

endpackage

### rtl/core/eapol_hb_rx_parser.sv
// ----------------------------------------------------------------------------
// eapol_hb_rx_parser
// Tracks position and header checks of a received frame and gathers the
// coded key bytes; gives the verdict for the closing byte.
// ----------------------------------------------------------------------------
module eapol_hb_rx_parser (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      byte_en,
    input  logic [7:0]                rx_byte,
    input  logic                      rx_last,
    output eapol_hb_pkg::rx_verdict_t verdict
);

    logic [eapol_hb_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [2:0]                     flags_reg, flags_next;
    logic [eapol_hb_pkg::POS_W-1:0] key_ofs_reg, key_ofs_next;
    logic [31:0]                    gather_reg, gather_next;
    logic [7:0]                     macs_reg [eapol_hb_pkg::MAC_BYTES];
    logic [9:0]                     key_end;
    logic                           type_ok;

    always_comb begin
        flags_next   = flags_reg;
        key_ofs_next = key_ofs_reg;
        gather_next  = gather_reg;
        pos_next     = (pos_reg == eapol_hb_pkg::POS_MAX) ? pos_reg : pos_reg + 1'b1;

        if ((pos_reg == eapol_hb_pkg::POS_TYPE_HI && rx_byte != 8'h88) ||
            (pos_reg == eapol_hb_pkg::POS_TYPE_LO && rx_byte != 8'h8E))
            flags_next[0] = 1'b1;
        if ((pos_reg == eapol_hb_pkg::POS_CODE && rx_byte != 8'h00) ||
            (pos_reg == eapol_hb_pkg::POS_SUBTYPE && rx_byte != 8'h03))
            flags_next[1] = 1'b1;
        if ((pos_reg == eapol_hb_pkg::POS_HB0 && rx_byte != 8'h00) ||
            (pos_reg == eapol_hb_pkg::POS_HB1 && rx_byte != 8'h1E) ||
            (pos_reg == eapol_hb_pkg::POS_SUBTYPE && rx_byte != 8'hFF) ||
            (pos_reg == eapol_hb_pkg::POS_HB3 && rx_byte != 8'hFF) ||
            (pos_reg == eapol_hb_pkg::POS_HB_TAIL && rx_byte != 8'hFF))
            flags_next[2] = 1'b1;
        if (pos_reg == eapol_hb_pkg::POS_KEY_OFS)
            key_ofs_next = eapol_hb_pkg::KEY_BASE + {1'b0, rx_byte};
        if (pos_reg > eapol_hb_pkg::POS_KEY_OFS && pos_reg >= key_ofs_reg &&
            {1'b0, pos_reg} < {1'b0, key_ofs_reg} + 10'd4)
            gather_next = {gather_reg[23:0], eapol_hb_pkg::code_byte(rx_byte)};

        // frame verdict, taken from the updated values
        key_end = {1'b0, key_ofs_next} + 10'd4;
        type_ok = !flags_next[0] && pos_next > eapol_hb_pkg::POS_TYPE_LO;
        verdict.succ = type_ok && !flags_next[1] &&
                       pos_next > eapol_hb_pkg::POS_KEY_OFS &&
                       {1'b0, pos_next} >= key_end;
        verdict.hb   = type_ok && !flags_next[2] &&
                       pos_next > eapol_hb_pkg::POS_HB_TAIL;
        verdict.local_mac = {macs_reg[0], macs_reg[1], macs_reg[2],
                             macs_reg[3], macs_reg[4], macs_reg[5]};
        verdict.dest_mac  = {macs_reg[6], macs_reg[7], macs_reg[8],
                             macs_reg[9], macs_reg[10], macs_reg[11]};
        verdict.key       = gather_next + eapol_hb_pkg::KEY_ADD;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            flags_reg   <= '0;
            key_ofs_reg <= '0;
            gather_reg  <= '0;
        end else if (byte_en) begin
            if (rx_last) begin
                pos_reg     <= '0;
                flags_reg   <= '0;
                key_ofs_reg <= '0;
                gather_reg  <= '0;
            end else begin
                pos_reg     <= pos_next;
                flags_reg   <= flags_next;
                key_ofs_reg <= key_ofs_next;
                gather_reg  <= gather_next;
            end
        end
    end

    // address bytes of the current frame
    always_ff @(posedge aclk) begin
        if (byte_en && pos_reg < eapol_hb_pkg::POS_W'(eapol_hb_pkg::MAC_BYTES))
            macs_reg[pos_reg[3:0]] <= rx_byte;
    end

endmodule

### rtl/core/eapol_hb_tx_framer.sv
// ----------------------------------------------------------------------------
// eapol_hb_tx_framer
// Holds the frozen MACs and the count snapshot of a send and walks the
// heartbeat frame one byte per advance.
// ----------------------------------------------------------------------------
module eapol_hb_tx_framer (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  eapol_hb_pkg::tx_start_t req,
    input  logic                    advance,
    output eapol_hb_pkg::tx_byte_t  tx
);

    logic                              busy_reg;
    logic [eapol_hb_pkg::TX_IDX_W-1:0] idx_reg;
    logic [95:0]                       macs_reg;
    logic [31:0]                       count_reg;
    logic [31:0]                       sum_reg;
    logic [7:0]                        raw;
    logic [1:0]                        sel;

    always_comb begin
        raw = eapol_hb_pkg::TX_TEMPLATE[idx_reg];
        sel = idx_reg[1:0] - eapol_hb_pkg::TX_KEY_POS[1:0];
        if (idx_reg < eapol_hb_pkg::TX_MAC_END) begin
            raw = macs_reg[7'd95 - {idx_reg[3:0], 3'b000} -: 8];
        end else if (idx_reg >= eapol_hb_pkg::TX_KEY_POS &&
                     idx_reg < eapol_hb_pkg::TX_KEY_POS + 6'd4) begin
            raw = eapol_hb_pkg::code_byte(sum_reg[5'd31 - {sel, 3'b000} -: 8]);
        end else if (idx_reg >= eapol_hb_pkg::TX_CNT_POS &&
                     idx_reg < eapol_hb_pkg::TX_CNT_POS + 6'd4) begin
            sel = idx_reg[1:0] - eapol_hb_pkg::TX_CNT_POS[1:0];
            case (sel)
                2'd0:    raw = eapol_hb_pkg::code_byte(count_reg[31:24]);
                2'd1:    raw = eapol_hb_pkg::code_byte(count_reg[23:16]);
                2'd2:    raw = eapol_hb_pkg::code_byte(count_reg[15:8] +
                                                       eapol_hb_pkg::TX_CNT_ADD2);
                default: raw = eapol_hb_pkg::code_byte(count_reg[7:0] +
                                                       eapol_hb_pkg::TX_CNT_ADD3);
            endcase
        end
        tx.busy = busy_reg;
        tx.data = raw;
        tx.last = (idx_reg == eapol_hb_pkg::TX_LAST_IDX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            macs_reg <= '0;
        end else begin
            if (req.start) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
                if (req.load_macs)
                    macs_reg <= req.macs;
            end else if (busy_reg && advance) begin
                if (idx_reg == eapol_hb_pkg::TX_LAST_IDX)
                    busy_reg <= 1'b0;
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            count_reg <= req.count;
            sum_reg   <= req.key_sum;
        end
    end

endmodule

### rtl/core/eapol_heartbeat_engine.sv
// ----------------------------------------------------------------------------
// eapol_heartbeat_engine
// 802.1X success capture, heartbeat counting and heartbeat frame generation.
// ----------------------------------------------------------------------------
// Status: a received byte that closes a frame shows its status on m_ in the
//   cycle after its transaction; other received bytes give no result.
// Throughput: one received byte per cycle while m_tready holds and no send
//   burst is running. A send request emits 45 bytes, stepped out by the
//   framer's byte counter and then registered in the output register, one per
//   cycle while m_tready holds; s_tready stays low for that whole burst.
// Reset: aresetn is synchronous, active low, and clears the control and
//   heartbeat state, the configuration registers and the output valid.
// ----------------------------------------------------------------------------
module eapol_heartbeat_engine (
    input  logic        aclk,
    input  logic        aresetn,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        s_tuser,    // [0] command
    input  logic        s_tlast,    // rx_last

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // [7:0] tx_byte, [8] frame_success,
                                    // [9] frame_heartbeat, [41:10] echo_count,
                                    // [73:42] echo_key_value, [79:74] zero
    output logic        m_tuser,    // [0] result_kind
    output logic        m_tlast,    // tx_last

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    // configuration registers
    logic        manual_mode_reg;
    logic [31:0] manual_key_reg;
    logic [31:0] manual_count_reg;
    logic [47:0] manual_dest_reg;
    logic [47:0] manual_local_reg;

    // heartbeat state
    logic [31:0] echo_key_reg, echo_key_next;
    logic [31:0] echo_number_reg, echo_number_next;
    logic [47:0] dest_addr_reg, dest_addr_next;
    logic [47:0] local_addr_reg, local_addr_next;
    logic        first_done_reg, first_done_next;

    // output register
    logic        m_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        out_kind_reg;
    logic        out_succ_reg;
    logic        out_hb_reg;
    logic [31:0] out_count_reg;
    logic [31:0] out_key_reg;

    logic                      out_free;
    logic                      in_xfer;
    logic                      rx_en;
    logic                      send_en;
    logic                      use_manual;
    logic [31:0]               key_eff;
    logic [31:0]               count_eff;
    logic [47:0]               dest_eff;
    logic [47:0]               local_eff;
    eapol_hb_pkg::rx_verdict_t verdict;
    eapol_hb_pkg::tx_start_t   tx_req;
    eapol_hb_pkg::tx_byte_t    tx;

    // Output register frees up when empty or taken this cycle; the input
    // is held off while the framer owns the output or the register is not free.
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = out_free && !tx.busy;
    assign in_xfer   = s_tvalid && s_tready;
    assign rx_en     = in_xfer && (s_tuser == eapol_hb_pkg::CMD_RX);
    assign send_en   = in_xfer && (s_tuser == eapol_hb_pkg::CMD_SEND);
    assign cfg_ready = 1'b1;

    eapol_hb_rx_parser u_rx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (rx_en),
        .rx_byte (s_tdata),
        .rx_last (s_tlast),
        .verdict (verdict)
    );

    // Manual registers are consulted only at the first send.
    assign use_manual = !first_done_reg && manual_mode_reg;
    assign key_eff    = use_manual ? manual_key_reg   : echo_key_reg;
    assign count_eff  = use_manual ? manual_count_reg : echo_number_reg;
    assign dest_eff   = use_manual ? manual_dest_reg  : dest_addr_reg;
    assign local_eff  = use_manual ? manual_local_reg : local_addr_reg;

    always_comb begin
        tx_req.start     = send_en;
        tx_req.load_macs = !first_done_reg;   // MACs freeze at the first send
        tx_req.macs      = {dest_eff, local_eff};
        tx_req.count     = count_eff;
        tx_req.key_sum   = key_eff + count_eff;
    end

    eapol_hb_tx_framer u_tx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tx_req),
        .advance (out_free),
        .tx      (tx)
    );

    always_comb begin
        echo_key_next    = echo_key_reg;
        echo_number_next = echo_number_reg;
        dest_addr_next   = dest_addr_reg;
        local_addr_next  = local_addr_reg;
        first_done_next  = first_done_reg;
        if (send_en) begin
            echo_key_next    = key_eff;
            echo_number_next = count_eff + 32'd1;
            dest_addr_next   = dest_eff;
            local_addr_next  = local_eff;
            first_done_next  = 1'b1;
        end else if (rx_en && s_tlast) begin
            if (verdict.succ) begin
                echo_key_next   = verdict.key;
                local_addr_next = verdict.local_mac;
                dest_addr_next  = verdict.dest_mac;
            end
            echo_number_next = (verdict.succ ? 32'd0 : echo_number_reg) +
                               {31'd0, verdict.hb};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_key_reg    <= '0;
            echo_number_reg <= '0;
            dest_addr_reg   <= '0;
            local_addr_reg  <= '0;
            first_done_reg  <= 1'b0;
        end else begin
            echo_key_reg    <= echo_key_next;
            echo_number_reg <= echo_number_next;
            dest_addr_reg   <= dest_addr_next;
            local_addr_reg  <= local_addr_next;
            first_done_reg  <= first_done_next;
        end
    end

    // configuration decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            manual_mode_reg  <= 1'b0;
            manual_key_reg   <= '0;
            manual_count_reg <= '0;
            manual_dest_reg  <= '0;
            manual_local_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                eapol_hb_pkg::CFG_MANUAL_MODE:  manual_mode_reg  <= cfg_data[0];
                eapol_hb_pkg::CFG_MANUAL_KEY:   manual_key_reg   <= cfg_data[31:0];
                eapol_hb_pkg::CFG_MANUAL_COUNT: manual_count_reg <= cfg_data[31:0];
                eapol_hb_pkg::CFG_MANUAL_DEST:  manual_dest_reg  <= cfg_data;
                eapol_hb_pkg::CFG_MANUAL_LOCAL: manual_local_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // output valid: frame status on a closing byte, frame bytes from the
    // framer during a burst, otherwise drain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= tx.busy || (rx_en && s_tlast);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (tx.busy) begin
                out_kind_reg  <= eapol_hb_pkg::KIND_TX;
                out_byte_reg  <= tx.data;
                out_last_reg  <= tx.last;
                out_succ_reg  <= 1'b0;
                out_hb_reg    <= 1'b0;
                out_count_reg <= echo_number_reg;
                out_key_reg   <= echo_key_reg;
            end else begin
                out_kind_reg  <= eapol_hb_pkg::KIND_STATUS;
                out_byte_reg  <= 8'h00;
                out_last_reg  <= 1'b0;
                out_succ_reg  <= verdict.succ;
                out_hb_reg    <= verdict.hb;
                out_count_reg <= echo_number_next;
                out_key_reg   <= echo_key_next;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_key_reg, out_count_reg, out_hb_reg, out_succ_reg,
                       out_byte_reg};

endmodule

### sim/tb_eapol_heartbeat_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eapol_heartbeat_engine
// Self-checking bench for the 802.1X heartbeat engine. Received frames are
// streamed byte by byte, and send requests are mixed in between and within
// them. A transaction-level predictor of the engine, running on every
// accepted input transaction, queues the transmit bytes and frame status it
// should produce. Each m_ transaction is then checked field by field against
// the oldest queued entry. Both stream sides idle at random, and one long
// output stall forces the input to back up.
// ----------------------------------------------------------------------------
module tb_eapol_heartbeat_engine;

    localparam int HB_BYTES    = 45;       // heartbeat frame length
    localparam int KEY_FIELD   = 'h9D;     // key bytes start here plus byte 0x1B
    localparam int RX_POS_TOP  = 511;      // receive position saturates here
    localparam int HOLD_CYCLES = 300;      // length of the long output stall

    // Heartbeat frame skeleton. MACs, coded key+count and coded count are
    // patched in per frame.
    localparam logic [0:44][7:0] HB_TEMPLATE = {
        {12{8'h00}},
        8'h88, 8'h8E, 8'h01, 8'hBF,
        8'h00, 8'h1E, 8'hFF, 8'hFF, 8'h37, 8'h77, 8'h7F, 8'h9F,
        8'hFF, 8'hFF, 8'hD9, 8'h13,
        8'hFF, 8'hFF, 8'h37, 8'h77, 8'h7F, 8'h9F, 8'hFF, 8'hFF,
        8'hF7, 8'h2B, 8'hFF, 8'hFF,
        8'h37, 8'h77, 8'h7F, 8'h3F, 8'hFF
    };

    // One output transaction as the engine should present it
    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic        last;
        logic        success;
        logic        heartbeat;
        logic [31:0] count;
        logic [31:0] key;
    } beat_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_PERIODIC,
        READY_SPARSE
    } ready_mode_e;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [7:0] rx_byte
    logic        s_tuser   = 1'b0;    // [0] command
    logic        s_tlast   = 1'b0;    // rx_last
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;             // [7:0] tx_byte, [8] frame_success,
                                      // [9] frame_heartbeat, [41:10] echo_count,
                                      // [73:42] echo_key_value
    logic        m_tuser;             // [0] result_kind
    logic        m_tlast;             // tx_last
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [47:0] cfg_data  = 48'd0;

    eapol_heartbeat_engine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a shadow of the engine's registers and parser
    // ------------------------------------------------------------------------
    logic        reg_mode;
    logic [31:0] reg_key, reg_count;
    logic [47:0] reg_dest, reg_local;

    logic [8:0]  rx_pos;
    logic        bad_type, bad_succ, bad_hb;   // per-frame mismatch marks
    int          key_start;
    logic [31:0] key_acc;
    logic [7:0]  mac_buf [12];
    logic [31:0] hb_key, hb_count;
    logic [47:0] dest_mac, local_mac;
    logic        sent_once;
    logic [95:0] frozen_macs;                  // dest then local, byte 0 on top

    beat_t       out_beats [$];                // transactions still owed on m_
    int          mismatch_count = 0;

    // Stimulus control
    logic [7:0]  frame_buf [$];
    bit          idle_enable = 1'b1;
    int          burst_left  = 0;
    bit          hold_go     = 1'b0;
    logic        hold_active = 1'b0;
    ready_mode_e ready_mode  = READY_ALWAYS;
    int          ready_tick  = 0;

    // Bit reverse then invert, as the heartbeat protocol codes its bytes
    function automatic logic [7:0] mirror_not(input logic [7:0] v);
        return ~{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
    endfunction

    function automatic void queue_beat(input logic kind, input logic [7:0] data,
                                       input logic last, input logic succ,
                                       input logic hb);
        beat_t b;
        b.kind      = kind;
        b.data      = data;
        b.last      = last;
        b.success   = succ;
        b.heartbeat = hb;
        b.count     = hb_count;
        b.key       = hb_key;
        out_beats.push_back(b);
    endfunction

    function automatic void clear_engine();
        reg_mode  = 1'b0;  reg_key = '0;  reg_count = '0;
        reg_dest  = '0;    reg_local = '0;
        rx_pos    = '0;    bad_type = 1'b0;  bad_succ = 1'b0;  bad_hb = 1'b0;
        key_start = 0;     key_acc = '0;
        foreach (mac_buf[i]) mac_buf[i] = 8'h00;
        hb_key    = '0;    hb_count = '0;
        dest_mac  = '0;    local_mac = '0;
        sent_once = 1'b0;  frozen_macs = '0;
    endfunction

    // Advance the shadow engine by one accepted input transaction
    function automatic void step_engine(input logic cmd, input logic [7:0] rxb,
                                        input logic rxl);
        logic [31:0] sum, n;
        logic [7:0]  fb;
        int          p, len;
        logic        type_ok, succ, hb;
        if (cmd == eapol_hb_pkg::CMD_SEND) begin
            if (!sent_once) begin
                // manual registers only matter at the very first send
                if (reg_mode) begin
                    hb_key    = reg_key;
                    hb_count  = reg_count;
                    dest_mac  = reg_dest;
                    local_mac = reg_local;
                end
                frozen_macs = {dest_mac, local_mac};
                sent_once   = 1'b1;
            end
            sum      = hb_key + hb_count;
            n        = hb_count;
            hb_count = n + 32'd1;          // every byte already shows the bumped count
            for (int i = 0; i < HB_BYTES; i++) begin
                if (i < 12)
                    fb = frozen_macs[95 - 8 * i -: 8];
                else if (i >= 'h18 && i <= 'h1B)
                    fb = mirror_not(sum[31 - 8 * (i - 'h18) -: 8]);
                else if (i == 'h22)
                    fb = mirror_not(n[31:24]);
                else if (i == 'h23)
                    fb = mirror_not(n[23:16]);
                else if (i == 'h24)
                    fb = mirror_not(n[15:8] + 8'h10);
                else if (i == 'h25)
                    fb = mirror_not(n[7:0] + 8'h2B);
                else
                    fb = HB_TEMPLATE[i];
                queue_beat(eapol_hb_pkg::KIND_TX, fb, i == HB_BYTES - 1, 1'b0, 1'b0);
            end
        end else begin
            p = rx_pos;
            if (p < 12) mac_buf[p] = rxb;
            if ((p == 'h0C && rxb != 8'h88) || (p == 'h0D && rxb != 8'h8E))
                bad_type = 1'b1;
            if ((p == 'h0F && rxb != 8'h00) || (p == 'h12 && rxb != 8'h03))
                bad_succ = 1'b1;
            if ((p == 'h10 && rxb != 8'h00) || (p == 'h11 && rxb != 8'h1E) ||
                (p == 'h12 && rxb != 8'hFF) || (p == 'h13 && rxb != 8'hFF) ||
                (p == 'h2C && rxb != 8'hFF))
                bad_hb = 1'b1;
            if (p == 'h1B) key_start = KEY_FIELD + rxb;
            if (p > 'h1B && p >= key_start && p < key_start + 4)
                key_acc = {key_acc[23:0], mirror_not(rxb)};
            if (p < RX_POS_TOP) rx_pos = rx_pos + 9'd1;
            if (!rxl) return;

            len     = rx_pos;
            type_ok = !bad_type && len > 'h0D;
            succ    = type_ok && !bad_succ && len > 'h1B && len >= key_start + 4;
            hb      = type_ok && !bad_hb && len > 'h2C;
            if (succ) begin
                hb_count  = '0;
                local_mac = {mac_buf[0], mac_buf[1], mac_buf[2],
                             mac_buf[3], mac_buf[4], mac_buf[5]};
                dest_mac  = {mac_buf[6], mac_buf[7], mac_buf[8],
                             mac_buf[9], mac_buf[10], mac_buf[11]};
                hb_key    = key_acc + 32'h0000_102B;
            end
            if (hb) hb_count = hb_count + 32'd1;
            rx_pos   = '0;
            bad_type = 1'b0;  bad_succ = 1'b0;  bad_hb = 1'b0;
            key_start = 0;
            key_acc  = '0;
            queue_beat(eapol_hb_pkg::KIND_STATUS, 8'h00, 1'b0, succ, hb);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every m_ transaction against the oldest expectation
    // ------------------------------------------------------------------------
    function automatic void flag_error(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: mismatch on %s, expected 0x%0h, got 0x%0h",
                     $realtime, what, want, got);
    endfunction

    always @(posedge aclk) begin
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (out_beats.size() == 0) begin
                flag_error("unexpected transaction (tdata low word)", 32'h0,
                           m_tdata[31:0]);
            end else begin
                want = out_beats.pop_front();
                if (m_tuser !== want.kind)
                    flag_error("result_kind", 32'(want.kind), 32'(m_tuser));
                if (m_tdata[7:0] !== want.data)
                    flag_error("tx_byte", 32'(want.data), 32'(m_tdata[7:0]));
                if (m_tlast !== want.last)
                    flag_error("tx_last", 32'(want.last), 32'(m_tlast));
                if (m_tdata[8] !== want.success)
                    flag_error("frame_success", 32'(want.success), 32'(m_tdata[8]));
                if (m_tdata[9] !== want.heartbeat)
                    flag_error("frame_heartbeat", 32'(want.heartbeat), 32'(m_tdata[9]));
                if (m_tdata[41:10] !== want.count)
                    flag_error("echo_count", want.count, m_tdata[41:10]);
                if (m_tdata[73:42] !== want.key)
                    flag_error("echo_key_value", want.key, m_tdata[73:42]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: m_tready follows a pattern picked anew at random whenever
    // ready_tick[6:0] is zero; the long hold-off overrides it.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        ready_tick <= ready_tick + 1;
        if (ready_tick[6:0] == 7'd0)
            ready_mode <= ready_mode_e'($urandom_range(0, 3));
        if (hold_active) begin
            m_tready <= 1'b0;
        end else begin
            case (ready_mode)
                READY_ALWAYS:   m_tready <= 1'b1;
                READY_COIN:     m_tready <= 1'($urandom_range(0, 1));
                READY_PERIODIC: m_tready <= (ready_tick % 7) >= 3;
                default:        m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Long stall, counted here so the sender can keep pushing meanwhile
    always begin
        wait (hold_go);
        @(posedge aclk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active <= 1'b0;
        hold_go = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Input side: one transaction per call, in bursts with random gaps.
    // tvalid is left high on return so back-to-back items need no dip.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic cmd, input logic [7:0] data, input logic last);
        if (idle_enable && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        step_engine(cmd, data, last);
    endtask

    task automatic send_request();
        // rx fields are don't-care
        send_item(eapol_hb_pkg::CMD_SEND, 8'($urandom), 1'($urandom));
    endtask

    // Stream frame_buf; optionally drop a send request somewhere inside it
    task automatic play_frame(input bit allow_send);
        for (int i = 0; i < frame_buf.size(); i++) begin
            if (allow_send && $urandom_range(0, 199) == 0) send_request();
            send_item(eapol_hb_pkg::CMD_RX, frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    // Drop valid and wait until the engine has nothing left to deliver
    task automatic settle();
        s_tvalid <= 1'b0;
        while (out_beats.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Only called while idle
    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            eapol_hb_pkg::CFG_MANUAL_MODE:  reg_mode  = val[0];
            eapol_hb_pkg::CFG_MANUAL_KEY:   reg_key   = val[31:0];
            eapol_hb_pkg::CFG_MANUAL_COUNT: reg_count = val[31:0];
            eapol_hb_pkg::CFG_MANUAL_DEST:  reg_dest  = val;
            eapol_hb_pkg::CFG_MANUAL_LOCAL: reg_local = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Frame builders
    // ------------------------------------------------------------------------
    function automatic void set_byte(input int pos, input logic [7:0] v);
        if (pos < frame_buf.size()) frame_buf[pos] = v;
    endfunction

    function automatic void fill_random(input int len);
        frame_buf.delete();
        repeat (len) frame_buf.push_back(8'($urandom));
    endfunction

    function automatic void make_success(input int ofs, input int len);
        fill_random(len);
        set_byte('h0C, 8'h88);
        set_byte('h0D, 8'h8E);
        set_byte('h0F, 8'h00);
        set_byte('h12, 8'h03);
        set_byte('h1B, 8'(ofs));
    endfunction

    function automatic void make_heartbeat(input int len);
        fill_random(len);
        set_byte('h0C, 8'h88);
        set_byte('h0D, 8'h8E);
        set_byte('h10, 8'h00);
        set_byte('h11, 8'h1E);
        set_byte('h12, 8'hFF);
        set_byte('h13, 8'hFF);
        set_byte('h2C, 8'hFF);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Manual mode with extreme values, before anything is sent
    task automatic test_reset_config();
        write_reg(eapol_hb_pkg::CFG_MANUAL_MODE,  {47'($urandom), 1'b1});
        write_reg(eapol_hb_pkg::CFG_MANUAL_KEY,   {16'($urandom), 32'hFFFF_FFFF});
        write_reg(eapol_hb_pkg::CFG_MANUAL_COUNT, {16'($urandom), 32'hFFFF_FFFF});
        write_reg(eapol_hb_pkg::CFG_MANUAL_DEST,  48'hFFFF_FFFF_FFFF);
        write_reg(eapol_hb_pkg::CFG_MANUAL_LOCAL, 48'h0000_0000_0001);
    endtask

    // Success header that ends before the key offset byte: nothing captured
    task automatic test_short_frames();
        make_success(0, 'h13);
        play_frame(1'b0);
    endtask

    // First send takes key, count and MACs from the registers; count wraps
    task automatic test_manual_first_send();
        send_request();
        send_request();
    endtask

    // Key capture at the nearest key offset with all-ones key bytes; a send
    // request in the middle of the frame leaves parsing intact
    task automatic test_success_capture();
        make_success(0, KEY_FIELD + 4);
        for (int i = 0; i < 4; i++) frame_buf[KEY_FIELD + i] = 8'hFF;
        for (int i = 0; i < frame_buf.size(); i++) begin
            if (i == 'h20) send_request();
            send_item(eapol_hb_pkg::CMD_RX, frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    // Heartbeat at minimum length; then a send that still carries the MACs
    // frozen at the first send
    task automatic test_heartbeat_count();
        make_heartbeat(HB_BYTES);
        play_frame(1'b0);
        send_request();
    endtask

    // Register sweep after the first send: low extremes, random values,
    // unused indexes, high extremes. None of it may change sent frames.
    task automatic test_config_sweep();
        settle();
        write_reg(eapol_hb_pkg::CFG_MANUAL_MODE,  48'd0);
        write_reg(eapol_hb_pkg::CFG_MANUAL_KEY,   48'd0);
        write_reg(eapol_hb_pkg::CFG_MANUAL_COUNT, 48'd0);
        write_reg(eapol_hb_pkg::CFG_MANUAL_DEST,  48'd0);
        write_reg(eapol_hb_pkg::CFG_MANUAL_LOCAL, 48'd0);
        send_request();
        settle();
        write_reg(eapol_hb_pkg::CFG_MANUAL_KEY,   {16'($urandom), 32'($urandom)});
        write_reg(eapol_hb_pkg::CFG_MANUAL_COUNT, {16'($urandom), 32'($urandom)});
        write_reg(eapol_hb_pkg::CFG_MANUAL_DEST,  {16'($urandom), 32'($urandom)});
        write_reg(eapol_hb_pkg::CFG_MANUAL_LOCAL, {16'($urandom), 32'($urandom)});
        for (int idx = eapol_hb_pkg::CFG_MANUAL_LOCAL + 1; idx < 8; idx++)
            write_reg(3'(idx), {16'($urandom), 32'($urandom)});
        write_reg(eapol_hb_pkg::CFG_MANUAL_MODE,  48'hFFFF_FFFF_FFFF);
        write_reg(eapol_hb_pkg::CFG_MANUAL_KEY,   48'hFFFF_FFFF_FFFF);
        write_reg(eapol_hb_pkg::CFG_MANUAL_COUNT, 48'hFFFF_FFFF_FFFF);
        write_reg(eapol_hb_pkg::CFG_MANUAL_DEST,  48'hFFFF_FFFF_FFFF);
        write_reg(eapol_hb_pkg::CFG_MANUAL_LOCAL, 48'hFFFF_FFFF_FFFF);
        send_request();
    endtask

    // Output held off for a long stretch while input keeps coming with no
    // gaps, so the engine backs up and drops s_tready
    task automatic test_backpressure();
        idle_enable = 1'b0;
        hold_go     = 1'b1;
        repeat (3) send_item(eapol_hb_pkg::CMD_RX, 8'($urandom), 1'b1);
        send_request();
        repeat (2) send_item(eapol_hb_pkg::CMD_RX, 8'($urandom), 1'b1);
        idle_enable = 1'b1;
    endtask

    // Short noise frames and send requests in random order
    task automatic test_random_traffic();
        repeat (4) begin
            idle_enable = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 60) begin
                fill_random($urandom_range(1, 3));
                play_frame(1'b1);
            end else begin
                send_request();
            end
        end
        idle_enable = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_engine();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_config();
        test_short_frames();
        test_manual_first_send();
        test_success_capture();
        test_heartbeat_count();
        test_config_sweep();
        test_backpressure();
        test_random_traffic();

        settle();
        if (mismatch_count == 0)
            $display("** eapol_heartbeat_engine: PASSED **");
        else
            $display("** eapol_heartbeat_engine: FAILED **");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("** eapol_heartbeat_engine: FAILED **");
        $finish;
    end

endmodule

### sim.f
rtl/core/eapol_hb_pkg.sv
rtl/core/eapol_hb_rx_parser.sv
rtl/core/eapol_hb_tx_framer.sv
rtl/core/eapol_heartbeat_engine.sv
sim/tb_eapol_heartbeat_engine.sv
